// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every clock outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2cmrt_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_pkg
// Types and constants for the I2C register transfer master.
// ----------------------------------------------------------------------------
package i2cmrt_pkg;

    typedef struct packed {
        logic       sda_level;
        logic       command_valid;
        logic       action;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic       write_byte_valid;
        logic [7:0] write_byte;
    } tick_in_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic [7:0] read_byte;
        logic       read_byte_valid;
        logic       write_byte_request;
        logic       busy_res;
        logic       done_res;
        logic       success;
    } tick_out_t;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] short_delay_ticks;
        logic [9:0] ack_timeout_polls;
    } cfg_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH,
        PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_POLL, PH_ACK_HOLD, PH_WAIT_DATA,
        PH_RD_HIGH, PH_RD_LOW, PH_MACK_A, PH_MACK_B, PH_MACK_C,
        PH_NACK_A, PH_NACK_B, PH_NACK_C, PH_STOP_A, PH_STOP_B, PH_STOP_C
    } phase_t;

    typedef enum logic [1:0] {ST_ADDR_W, ST_REG, ST_ADDR_R, ST_DATA} stage_t;

    localparam logic [1:0] REG_HALF  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_POLLS = 2'd2;

    localparam int unsigned QueueDepth = 2;

endpackage

// ===== hdl/i2cmrt_regs.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_regs
// APB register file for the bus timing settings.
// ----------------------------------------------------------------------------
module i2cmrt_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output i2cmrt_pkg::cfg_t   cfg
);
    import i2cmrt_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= 8'd5;
            cfg_reg.short_delay_ticks <= 8'd1;
            cfg_reg.ack_timeout_polls <= 10'd200;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_HALF:  cfg_reg.half_period_ticks <= pwdata[7:0];
                REG_SHORT: cfg_reg.short_delay_ticks <= pwdata[7:0];
                REG_POLLS: cfg_reg.ack_timeout_polls <= pwdata[9:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            REG_HALF:  prdata = {24'd0, cfg_reg.half_period_ticks};
            REG_SHORT: prdata = {24'd0, cfg_reg.short_delay_ticks};
            REG_POLLS: prdata = {22'd0, cfg_reg.ack_timeout_polls};
            default:   prdata = 32'd0;
        endcase
    end
endmodule

// ===== hdl/i2cmrt_queue.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_queue
// Short tick queue between the input side and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cmrt_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  i2cmrt_pkg::tick_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output i2cmrt_pkg::tick_in_t  out_data
);
    import i2cmrt_pkg::*;

    tick_in_t mem_reg [QueueDepth];
    logic     wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic push, pop;

    assign in_stall  = (count_reg == 2'(QueueDepth));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    `include "assert_macros.svh"
    `ASSERT_CLK(a_count_bound, count_reg <= 2'(QueueDepth), "queue overfilled")
    `ASSERT_CLK(a_pop_dec, (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1), "queue count not reduced on pop")
    `ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && out_data == $past(out_data)), "stalled queue output changed")
endmodule

// ===== hdl/i2cmrt_seq.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_seq
// Bus sequencer: one tick per cycle unless a pending result is stalled, registered result item.
// ----------------------------------------------------------------------------
module i2cmrt_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  i2cmrt_pkg::cfg_t       cfg,
    input  logic                   tin_valid,
    output logic                   tin_stall,
    input  i2cmrt_pkg::tick_in_t   tin,
    output logic                   res_valid,
    input  logic                   res_stall,
    output i2cmrt_pkg::tick_out_t  res
);
    import i2cmrt_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [9:0] dly_reg, dly_next;
    logic [7:0] shf_reg, shf_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] left_reg, left_next;
    logic [6:0] dev_reg, dev_next;
    logic [7:0] rga_reg, rga_next;
    logic       dir_reg, dir_next;
    stage_t     stg_reg, stg_next;
    logic       ok_reg, ok_next;
    logic       vld_reg;
    tick_out_t  out_reg, out_next;
    logic       step;
    logic       rdv, done;
    logic [3:0] bit_inc;
    logic [7:0] left_dec;
    logic [1:0] lines;

    assign tin_stall = vld_reg && res_stall;
    assign step      = tin_valid && !tin_stall;
    assign res_valid = vld_reg;
    assign res       = out_reg;
    assign bit_inc   = bit_reg + 4'd1;
    assign left_dec  = left_reg - 8'd1;

    function automatic logic [9:0] dly_of(phase_t p, cfg_t c);
        logic [7:0] d;
        d = (p == PH_STOP_A || p == PH_NACK_A) ? c.short_delay_ticks : c.half_period_ticks;
        return (d == 8'd0) ? 10'd1 : {2'b00, d};
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        dly_next   = dly_reg;
        shf_next   = shf_reg;
        bit_next   = bit_reg;
        left_next  = left_reg;
        dev_next   = dev_reg;
        rga_next   = rga_reg;
        dir_next   = dir_reg;
        stg_next   = stg_reg;
        ok_next    = ok_reg;
        rdv        = 1'b0;
        done       = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (tin.command_valid)
            begin
                dir_next   = tin.action;
                dev_next   = tin.device_address;
                rga_next   = tin.register_address;
                left_next  = tin.byte_count;
                ok_next    = 1'b0;
                stg_next   = ST_ADDR_W;
                phase_next = PH_START_A;
            end
        end
        else if (phase_reg == PH_WAIT_DATA)
        begin
            if (tin.write_byte_valid)
            begin
                left_next  = left_dec;
                stg_next   = ST_DATA;
                shf_next   = tin.write_byte;
                bit_next   = 4'd0;
                phase_next = PH_BIT_LOW;
            end
        end
        else if (phase_reg != PH_ACK_POLL && dly_reg > 10'd1)
        begin
            dly_next = dly_reg - 10'd1;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_START_A: phase_next = PH_START_B;
                PH_START_B:
                begin
                    shf_next   = {dev_reg, stg_reg == ST_ADDR_R};
                    bit_next   = 4'd0;
                    phase_next = PH_BIT_LOW;
                end
                PH_BIT_LOW: phase_next = PH_BIT_HIGH;
                PH_BIT_HIGH:
                begin
                    bit_next   = bit_inc;
                    shf_next   = {shf_reg[6:0], 1'b0};
                    phase_next = (bit_inc < 4'd8) ? PH_BIT_LOW : PH_ACK_LOW;
                end
                PH_ACK_LOW: phase_next = PH_ACK_HIGH;
                PH_ACK_HIGH, PH_ACK_POLL:
                begin
                    // ACK_HIGH restarts the poll count at zero
                    if (tin.sda_level == 1'b0)
                    begin
                        phase_next = PH_ACK_HOLD;
                    end
                    else if ((phase_reg == PH_ACK_HIGH ? 10'd0 : dly_reg)
                             >= cfg.ack_timeout_polls)
                    begin
                        ok_next    = 1'b0;
                        phase_next = PH_STOP_A;
                    end
                    else
                    begin
                        dly_next   = (phase_reg == PH_ACK_HIGH) ? 10'd1 : dly_reg + 10'd1;
                        phase_next = PH_ACK_POLL;
                    end
                end
                PH_ACK_HOLD:
                begin
                    unique case (stg_reg)
                        ST_ADDR_W:
                        begin
                            stg_next   = ST_REG;
                            shf_next   = rga_reg;
                            bit_next   = 4'd0;
                            phase_next = PH_BIT_LOW;
                        end
                        ST_REG:
                        begin
                            if (dir_reg)
                            begin
                                stg_next   = ST_ADDR_R;
                                phase_next = PH_START_A;
                            end
                            else if (left_reg == 8'd0)
                            begin
                                ok_next    = 1'b1;
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                phase_next = PH_WAIT_DATA;
                            end
                        end
                        ST_ADDR_R:
                        begin
                            if (left_reg == 8'd0)
                            begin
                                ok_next    = 1'b1;
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                shf_next   = 8'd0;
                                bit_next   = 4'd0;
                                phase_next = PH_RD_HIGH;
                            end
                        end
                        default:
                        begin
                            if (left_reg == 8'd0)
                            begin
                                ok_next    = 1'b1;
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                phase_next = PH_WAIT_DATA;
                            end
                        end
                    endcase
                end
                PH_RD_HIGH:
                begin
                    shf_next   = {shf_reg[6:0], tin.sda_level};
                    phase_next = PH_RD_LOW;
                end
                PH_RD_LOW:
                begin
                    bit_next = bit_inc;
                    if (bit_inc < 4'd8)
                    begin
                        phase_next = PH_RD_HIGH;
                    end
                    else
                    begin
                        left_next  = left_dec;
                        phase_next = (left_dec == 8'd0) ? PH_NACK_A : PH_MACK_A;
                        rdv        = 1'b1;
                    end
                end
                PH_MACK_A: phase_next = PH_MACK_B;
                PH_MACK_B: phase_next = PH_MACK_C;
                PH_MACK_C:
                begin
                    shf_next   = 8'd0;
                    bit_next   = 4'd0;
                    phase_next = PH_RD_HIGH;
                end
                PH_NACK_A: phase_next = PH_NACK_B;
                PH_NACK_B: phase_next = PH_NACK_C;
                PH_NACK_C:
                begin
                    ok_next    = 1'b1;
                    phase_next = PH_STOP_A;
                end
                PH_STOP_A: phase_next = PH_STOP_B;
                PH_STOP_B: phase_next = PH_STOP_C;
                default:
                begin
                    phase_next = PH_IDLE;
                    dly_next   = 10'd0;
                    done       = 1'b1;
                end
            endcase
            if (phase_next == PH_WAIT_DATA || phase_next == PH_IDLE)
            begin
                dly_next = 10'd0;
            end
            else if (phase_next != phase_reg && phase_next != PH_ACK_POLL)
            begin
                dly_next = dly_of(phase_next, cfg);
            end
        end
        if (phase_reg == PH_WAIT_DATA && phase_next == PH_BIT_LOW)
        begin
            dly_next = dly_of(PH_BIT_LOW, cfg);
        end
        if (phase_reg == PH_IDLE && phase_next == PH_START_A)
        begin
            dly_next = dly_of(PH_START_A, cfg);
        end
        // a segment re-entering itself still reloads its delay
        if (phase_reg == phase_next && phase_reg != PH_IDLE && phase_reg != PH_WAIT_DATA
            && phase_reg != PH_ACK_POLL && !(dly_reg > 10'd1))
        begin
            dly_next = dly_of(phase_next, cfg);
        end

        unique case (phase_next) inside
            PH_START_B, PH_MACK_B, PH_STOP_B: lines = 2'b10;
            PH_BIT_LOW:  lines = {~shf_next[7], 1'b1};
            PH_BIT_HIGH: lines = {~shf_next[7], 1'b0};
            PH_ACK_LOW, PH_ACK_HOLD, PH_WAIT_DATA, PH_RD_LOW, PH_NACK_A, PH_NACK_C:
                lines = 2'b01;
            PH_MACK_A, PH_MACK_C, PH_STOP_A: lines = 2'b11;
            default: lines = 2'b00;
        endcase

        out_next.scl_pull_low       = lines[0];
        out_next.sda_pull_low       = lines[1];
        out_next.read_byte          = rdv ? shf_next : 8'd0;
        out_next.read_byte_valid    = rdv;
        out_next.write_byte_request = (phase_next == PH_WAIT_DATA);
        out_next.busy_res           = (phase_next != PH_IDLE);
        out_next.done_res           = done;
        out_next.success            = done && ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg  <= out_next;
            shf_reg  <= shf_next;
            left_reg <= left_next;
            dev_reg  <= dev_next;
            rga_reg  <= rga_next;
            dir_reg  <= dir_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            dly_reg   <= 10'd0;
            bit_reg   <= 4'd0;
            stg_reg   <= ST_ADDR_W;
            ok_reg    <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                dly_reg   <= dly_next;
                bit_reg   <= bit_next;
                stg_reg   <= stg_next;
                ok_reg    <= ok_next;
            end
            if (step)
                vld_reg <= 1'b1;
            else if (!res_stall)
                vld_reg <= 1'b0;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_idle_quiet, phase_reg == PH_IDLE && step && !tin.command_valid,
                 phase_next == PH_IDLE, "idle left without command")
    `ASSERT_IMPL(a_done_idle, step && done, phase_next == PH_IDLE, "done outside stop")
    `ASSERT_IMPL(a_bits, phase_reg == PH_BIT_LOW || phase_reg == PH_RD_HIGH,
                 bit_reg < 4'd8, "bit count overrun")
endmodule

// ===== hdl/i2c_master_register_transfer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// I2C master for register read and write transfers, one timing tick per item.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// tick in  | in_valid / in_stall  | in_data  (tick_in_t)
// tick out | out_valid / out_stall| out_data (tick_out_t)
// config   | APB psel/penable     | pwdata / prdata
//
// One tick item per cycle sustained while the output does not stall; its result
// passes through the queue and then the output register before it appears.
// Front queue of two items decouples input from sequencer stalls; with the
// output stalled, the input stalls once the queue and output register are full.
// Reset leaves the sequencer idle, no result valid, timings at their defaults.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  i2cmrt_pkg::tick_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output i2cmrt_pkg::tick_out_t  out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import i2cmrt_pkg::*;

    cfg_t     cfg;
    logic     q_valid, q_stall;
    tick_in_t q_data;

    i2cmrt_regs u_regs (.clk, .rst_n, .psel, .penable, .pwrite, .paddr,
                        .pwdata, .prdata, .pready, .cfg);

    i2cmrt_queue u_queue (.clk, .rst_n, .in_valid, .in_stall, .in_data,
                          .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data));

    i2cmrt_seq u_seq (.clk, .rst_n, .cfg, .tin_valid(q_valid), .tin_stall(q_stall),
                      .tin(q_data), .res_valid(out_valid), .res_stall(out_stall),
                      .res(out_data));
endmodule

// ===== verif/i2c_master_register_transfer_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_checker
// Watches the tick and config channels, predicts the I2C master's output for
// every accepted tick item and compares each returned item field by field.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_checker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  i2cmrt_pkg::tick_in_t   in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  i2cmrt_pkg::tick_out_t  out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    output int                     errors,
    output int                     pending,
    output logic                   bus_idle
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2cmrt_pkg::*;

    // predicted sequencer state
    logic [7:0] half_ticks;
    logic [7:0] short_ticks;
    logic [9:0] poll_limit;
    phase_t     ph;
    stage_t     stg;
    logic [9:0] dly;
    logic [7:0] shreg;
    logic [3:0] bitn;
    logic [7:0] left;
    logic [6:0] dev;
    logic [7:0] regaddr;
    logic       dir;
    logic       ok;

    tick_out_t  expected_ticks[$];
    int         err_count;

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic chk_field(string nm, logic [7:0] got, logic [7:0] exp);
        if (got !== exp)
            report($sformatf("%s got %0h expected %0h", nm, got, exp));
    endtask

    function automatic void enter_seg(phase_t p);
        logic [7:0] d;
        d = (p == PH_STOP_A || p == PH_NACK_A) ? short_ticks : half_ticks;
        ph = p;
        dly = (d == 0) ? 10'd1 : {2'b00, d};
    endfunction

    function automatic void load_byte(logic [7:0] v);
        shreg = v;
        bitn = 0;
        enter_seg(PH_BIT_LOW);
    endfunction

    function automatic void finish_ok();
        ok = 1'b1;
        enter_seg(PH_STOP_A);
    endfunction

    function automatic void poll_ack(logic sda);
        if (!sda)
            enter_seg(PH_ACK_HOLD);
        else if (dly >= poll_limit)
        begin
            ok = 1'b0;
            enter_seg(PH_STOP_A);
        end
        else
        begin
            dly++;
            ph = PH_ACK_POLL;
        end
    endfunction

    function automatic void wait_or_stop();
        if (left == 0)
            finish_ok();
        else
        begin
            ph = PH_WAIT_DATA;
            dly = 0;
        end
    endfunction

    function automatic void after_ack();
        case (stg)
            ST_ADDR_W:
            begin
                stg = ST_REG;
                load_byte(regaddr);
            end
            ST_REG:
                if (dir)
                begin
                    stg = ST_ADDR_R;
                    enter_seg(PH_START_A);
                end
                else
                    wait_or_stop();
            ST_ADDR_R:
                if (left == 0)
                    finish_ok();
                else
                begin
                    shreg = 0;
                    bitn = 0;
                    enter_seg(PH_RD_HIGH);
                end
            default:
                wait_or_stop();
        endcase
    endfunction

    // end of a timed segment
    function automatic void advance(input logic sda, output logic rdv, output logic dn);
        rdv = 1'b0;
        dn = 1'b0;
        case (ph)
            PH_START_A:  enter_seg(PH_START_B);
            PH_START_B:  load_byte({dev, stg == ST_ADDR_R});
            PH_BIT_LOW:  enter_seg(PH_BIT_HIGH);
            PH_BIT_HIGH:
            begin
                bitn++;
                shreg = {shreg[6:0], 1'b0};
                enter_seg(bitn < 8 ? PH_BIT_LOW : PH_ACK_LOW);
            end
            PH_ACK_LOW:  enter_seg(PH_ACK_HIGH);
            PH_ACK_HIGH:
            begin
                dly = 0;
                poll_ack(sda);
            end
            PH_ACK_HOLD: after_ack();
            PH_RD_HIGH:
            begin
                shreg = {shreg[6:0], sda};
                enter_seg(PH_RD_LOW);
            end
            PH_RD_LOW:
            begin
                bitn++;
                if (bitn < 8)
                    enter_seg(PH_RD_HIGH);
                else
                begin
                    left--;
                    enter_seg(left == 0 ? PH_NACK_A : PH_MACK_A);
                    rdv = 1'b1;
                end
            end
            PH_MACK_A:   enter_seg(PH_MACK_B);
            PH_MACK_B:   enter_seg(PH_MACK_C);
            PH_MACK_C:
            begin
                shreg = 0;
                bitn = 0;
                enter_seg(PH_RD_HIGH);
            end
            PH_NACK_A:   enter_seg(PH_NACK_B);
            PH_NACK_B:   enter_seg(PH_NACK_C);
            PH_NACK_C:   finish_ok();
            PH_STOP_A:   enter_seg(PH_STOP_B);
            PH_STOP_B:   enter_seg(PH_STOP_C);
            default:
            begin
                ph = PH_IDLE;
                dly = 0;
                dn = 1'b1;
            end
        endcase
    endfunction

    // {sda low, scl low}
    function automatic logic [1:0] line_drives();
        case (ph) inside
            PH_START_B:  return 2'b10;
            PH_BIT_LOW:  return {~shreg[7], 1'b1};
            PH_BIT_HIGH: return {~shreg[7], 1'b0};
            PH_ACK_LOW, PH_ACK_HOLD, PH_WAIT_DATA, PH_RD_LOW, PH_NACK_A, PH_NACK_C:
                return 2'b01;
            PH_MACK_A, PH_MACK_C, PH_STOP_A: return 2'b11;
            PH_MACK_B, PH_STOP_B: return 2'b10;
            default:     return 2'b00;
        endcase
    endfunction

    function automatic tick_out_t predict_tick(tick_in_t t);
        tick_out_t  r;
        logic       rdv;
        logic       dn;
        logic [1:0] ln;
        rdv = 1'b0;
        dn = 1'b0;
        if (ph == PH_IDLE)
        begin
            if (t.command_valid)
            begin
                dir = t.action;
                dev = t.device_address;
                regaddr = t.register_address;
                left = t.byte_count;
                ok = 1'b0;
                stg = ST_ADDR_W;
                enter_seg(PH_START_A);
            end
        end
        else if (ph == PH_WAIT_DATA)
        begin
            if (t.write_byte_valid)
            begin
                left--;
                stg = ST_DATA;
                load_byte(t.write_byte);
            end
        end
        else if (ph == PH_ACK_POLL)
            poll_ack(t.sda_level);
        else if (dly > 1)
            dly--;
        else
            advance(t.sda_level, rdv, dn);
        ln = line_drives();
        r.scl_pull_low       = ln[0];
        r.sda_pull_low       = ln[1];
        r.read_byte          = rdv ? shreg : 8'h00;
        r.read_byte_valid    = rdv;
        r.write_byte_request = (ph == PH_WAIT_DATA);
        r.busy_res           = (ph != PH_IDLE);
        r.done_res           = dn;
        r.success            = dn && ok;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_out_t e;
        if (!rst_n)
        begin
            half_ticks = 8'd5;
            short_ticks = 8'd1;
            poll_limit = 10'd200;
            ph = PH_IDLE;
            stg = ST_ADDR_W;
            dly = 0;
            shreg = 0;
            bitn = 0;
            left = 0;
            dev = 0;
            regaddr = 0;
            dir = 0;
            ok = 0;
            expected_ticks.delete();
            err_count = 0;
            errors <= 0;
            pending <= 0;
            bus_idle <= 1'b1;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_HALF:  half_ticks = pwdata[7:0];
                    REG_SHORT: short_ticks = pwdata[7:0];
                    REG_POLLS: poll_limit = pwdata[9:0];
                    default: ;
                endcase
            // a result never leaves in the cycle its tick is accepted, so pop first
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                    report("result item with nothing expected");
                else
                begin
                    e = expected_ticks.pop_front();
                    chk_field("scl_pull_low", out_data.scl_pull_low, e.scl_pull_low);
                    chk_field("sda_pull_low", out_data.sda_pull_low, e.sda_pull_low);
                    chk_field("read_byte", out_data.read_byte, e.read_byte);
                    chk_field("read_byte_valid", out_data.read_byte_valid, e.read_byte_valid);
                    chk_field("write_byte_request", out_data.write_byte_request,
                              e.write_byte_request);
                    chk_field("busy_res", out_data.busy_res, e.busy_res);
                    chk_field("done_res", out_data.done_res, e.done_res);
                    chk_field("success", out_data.success, e.success);
                end
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(predict_tick(in_data));
            errors <= err_count;
            pending <= expected_ticks.size();
            bus_idle <= (ph == PH_IDLE);
        end
    end

endmodule

// ===== verif/i2c_master_register_transfer_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_tb
// Drives tick items and register settings into the I2C register transfer
// master: directed transfers first, then random ticks under several timing
// settings and idling patterns. The checker does prediction and comparison.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cmrt_pkg::*;

    localparam int CycleLimit = 1000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    tick_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    tick_out_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    logic        bus_idle;
    int          cycles;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_left;
    bit          hold_req;
    bit          hold_done;
    int          ticks_sent;
    int          cmds_sent;

    i2c_master_register_transfer uut (.*);

    i2c_master_register_transfer_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 60;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_tick(tick_in_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        if (t.command_valid)
            cmds_sent++;
        ticks_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // idle ticks until the transfer has ended, then let all results arrive
    task automatic finish_transfer(logic sda);
        tick_in_t t;
        t = '0;
        t.sda_level = sda;
        t.write_byte_valid = 1'b1;
        t.write_byte = 8'($urandom_range(255));
        send_tick(t);
        do
        begin
            t.write_byte = 8'($urandom_range(255));
            send_tick(t);
        end
        while (!bus_idle);
        in_valid <= 1'b0;
        // let the count of the last item land before waiting on it
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_transfer(logic act, logic [6:0] da, logic [7:0] ra,
                                logic [7:0] cnt, logic sda);
        tick_in_t t;
        t = '0;
        t.command_valid = 1'b1;
        t.action = act;
        t.device_address = da;
        t.register_address = ra;
        t.byte_count = cnt;
        t.sda_level = sda;
        send_tick(t);
        finish_transfer(sda);
    endtask

    task automatic random_ticks(int n, int max_cnt);
        tick_in_t t;
        for (int i = 0; i < n; i++)
        begin
            t.sda_level        = ($urandom_range(99) < 25);
            t.command_valid    = ($urandom_range(99) < 20);
            t.action           = 1'($urandom_range(1));
            t.device_address   = 7'($urandom_range(127));
            t.register_address = 8'($urandom_range(255));
            t.byte_count       = 8'($urandom_range(max_cnt));
            t.write_byte_valid = 1'($urandom_range(1));
            t.write_byte       = 8'($urandom_range(255));
            if (i == n / 2 && !hold_done)
                hold_req = 1'b1;
            send_tick(t);
        end
        finish_transfer(1'b0);
    endtask

    task automatic set_timing(int half, int short_d, int polls);
        reg_write(REG_HALF, half);
        reg_write(REG_SHORT, short_d);
        reg_write(REG_POLLS, polls);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cycles = 0;
        hold_left = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        ticks_sent = 0;
        cmds_sent = 0;
        send_idle_pct = 6;
        stall_pct = 77;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero-length transfers, a missing acknowledge
        set_timing(1, 1, 1);
        run_transfer(1'b0, 7'h7f, 8'hff, 8'd0, 1'b0);
        run_transfer(1'b1, 7'h00, 8'h00, 8'd0, 1'b0);
        run_transfer(1'b0, 7'h33, 8'h0f, 8'd1, 1'b1);

        random_ticks(70, 2);

        send_idle_pct = 77;
        stall_pct = 6;
        set_timing(3, 2, 1023);
        random_ticks(70, 1);

        send_idle_pct = 0;
        stall_pct = 0;
        set_timing(1, 1, 4);
        random_ticks(40, 1);

        send_idle_pct = 6;
        stall_pct = 77;
        set_timing(2, 3, 5);
        random_ticks(60, 2);

        $display("sent %0d tick items, %0d with a command, over four timing settings",
                 ticks_sent, cmds_sent);
        $display("idling patterns varied, one long output hold-off applied");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
